[rtl/core/cqac_pkg.sv]
// Shared types and constants for class quota admission control.
// Used by the top level, cqac_quota and cqac_checker; no dependencies of its own.
`default_nettype none

package cqac_pkg;

  // Sizing of the block
  localparam int GLOBAL_CAP  = 64;
  localparam int QUEUE_DEPTH = 256;
  localparam int TAG_BITS    = 16;

  // Field widths fixed by the interface
  localparam int CNT_W     = 7;
  localparam int QUOTA_W   = 7;
  localparam int TAG_W     = 16;
  localparam int CLS_W     = 2;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;

  // Stream widths
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 3;

  // Task queue geometry
  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = TAG_BITS + CLS_W;

  // Quota reset values
  localparam logic [QUOTA_W-1:0] FWD_QUOTA_RST = QUOTA_W'(10);
  localparam logic [QUOTA_W-1:0] REV_QUOTA_RST = QUOTA_W'(4);
  localparam logic [QUOTA_W-1:0] REF_QUOTA_RST = QUOTA_W'(2);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FWD_QUOTA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REV_QUOTA = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_REF_QUOTA = CFG_IDX_W'(2);

  // Class codes
  localparam logic [CLS_W-1:0] CLS_FWD = CLS_W'(0);
  localparam logic [CLS_W-1:0] CLS_REV = CLS_W'(1);
  localparam logic [CLS_W-1:0] CLS_REF = CLS_W'(2);
  localparam logic [CLS_W-1:0] CLS_ALT = CLS_W'(3);

  // Operation codes; any op with the high bit set is a completion
  localparam logic [OP_W-1:0] OP_SUBMIT = OP_W'(0);
  localparam logic [OP_W-1:0] OP_TAKE   = OP_W'(1);
  localparam int              OP_COMPL_BIT = 1;

  typedef enum logic [2:0] {
    V_ADMIT     = 3'd0,
    V_REJ_CAP   = 3'd1,
    V_REJ_CLASS = 3'd2,
    V_REJ_FULL  = 3'd3,
    V_TAKEN     = 3'd4,
    V_EMPTY     = 3'd5,
    V_DONE      = 3'd6
  } verdict_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDATA
  } state_e;

  // Counter update request from the control path
  typedef struct packed {
    logic             commit;
    logic             dec_en;
    logic [CLS_W-1:0] dec_cls;
    logic             inc_en;
    logic [CLS_W-1:0] inc_cls;
  } cnt_upd_t;

  // In-flight counts
  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] fwd;
    logic [CNT_W-1:0] rev;
    logic [CNT_W-1:0] refr;
  } cnt_t;

  // Admission check status
  typedef struct packed {
    logic cap_hit;
    logic fits;
  } admit_t;

endpackage

`default_nettype wire

[rtl/core/class_quota_admission_control.sv]
// Class quota admission control: a task queue with per-class in-flight quotas.
//
// Channels: s_axis_* carries request items (tuser = op), m_axis_* carries one
// result item per request (tuser = verdict), cfg_* writes the three quota
// registers by index (forward, reverse, refresh) and is always ready.
// An accepted request is held in a request register and worked on in the next
// cycle. Completions, rejections, admissions without eviction and takes from
// an empty queue finish there, and their result is registered once the output
// register is free. A take, or a driver-initiated submit that evicts the oldest
// task, reads the head entry of the task RAM first and commits from ST_RDATA.
// The block works on one item at a time and accepts no new request until the
// current one has committed. Entries are written only at commit and read only
// in a later request's ST_EXEC, so no access to one entry overlaps another.
// Reset empties the queue, clears all counts and restores the default quotas;
// queue entries are only read after being written, so no clearing pass runs.
// While the receiver stalls, the finished result waits in the output register;
// the next request is still accepted and worked up to its commit, where it
// waits until the output register frees.
// Depends on cqac_pkg, cqac_quota and cqac_ram.
`default_nettype none

module class_quota_admission_control
  import cqac_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Requests
  input  wire logic                  s_axis_tvalid_i,
  output      logic                  s_axis_tready_o,
  // [1:0] req_class, [2] drv_prio, [18:3] task_tag, [19] success,
  // [20] timeout, [23:21] zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [1:0] op
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser_i,
  // Results
  output      logic                  m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // [0] dropped, [16:1] item_tag, [18:17] item_class, [25:19] in_flight_total,
  // [32:26] in_flight_fwd, [39:33] in_flight_rev, [46:40] in_flight_ref,
  // [47] zero
  output      logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // [2:0] verdict
  output      logic [OUT_USER_W-1:0] m_axis_tuser_o,
  // Configuration
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [QUOTA_W-1:0]    cfg_data_i
);

  state_e               state_q, state_d;
  logic [OP_W-1:0]      op_q;
  logic [CLS_W-1:0]     cls_q;
  logic                 drv_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic [PTR_W-1:0]     head_q;
  logic [FILL_W-1:0]    fill_q;
  logic                 out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  logic                 accept, out_free, commit, need_read, evict, pop;
  logic                 fifo_full, fifo_empty;
  verdict_e             verdict;
  logic [CLS_W-1:0]     in_cls;
  logic [PTR_W+1:0]     tail_sum;
  logic [PTR_W-1:0]     tail, head_inc;
  logic [ENTRY_W-1:0]   rd_data;
  logic [TAG_BITS-1:0]  rd_tag;
  logic [CLS_W-1:0]     rd_cls;
  logic [TAG_W-1:0]     item_tag;
  logic [CLS_W-1:0]     item_cls;
  cnt_upd_t             upd;
  cnt_t                 cnt_nx;
  admit_t               adm;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Class code 3 is served as reverse
  assign in_cls = (s_axis_tdata_i[1:0] == CLS_ALT) ? CLS_REV : s_axis_tdata_i[1:0];

  // Request register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= s_axis_tuser_i;
      cls_q <= in_cls;
      drv_q <= s_axis_tdata_i[2];
      tag_q <= s_axis_tdata_i[3 +: TAG_BITS];
    end
  end

  // Request decode and verdict
  assign fifo_full  = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign fifo_empty = (fill_q == '0);

  always_comb begin
    if (op_q[OP_COMPL_BIT]) begin
      verdict = V_DONE;
    end else if (op_q == OP_TAKE) begin
      verdict = fifo_empty ? V_EMPTY : V_TAKEN;
    end else if (adm.cap_hit) begin
      verdict = V_REJ_CAP;
    end else if (!adm.fits) begin
      verdict = V_REJ_CLASS;
    end else if (fifo_full && !drv_q) begin
      verdict = V_REJ_FULL;
    end else begin
      verdict = V_ADMIT;
    end
  end

  assign evict     = (verdict == V_ADMIT) && fifo_full;
  assign pop       = (verdict == V_TAKEN) || evict;
  assign need_read = pop;

  // Sequencer
  always_comb begin
    state_d = state_q;
    commit  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (need_read) begin
          state_d = ST_RDATA;
        end else if (out_free) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RDATA: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Head entry fields, valid in ST_RDATA
  assign rd_tag = rd_data[TAG_BITS-1:0];
  assign rd_cls = rd_data[ENTRY_W-1 -: CLS_W];

  // Counter update request
  always_comb begin
    upd.commit  = commit;
    upd.dec_en  = op_q[OP_COMPL_BIT] || evict;
    upd.dec_cls = op_q[OP_COMPL_BIT] ? cls_q : rd_cls;
    upd.inc_en  = (verdict == V_ADMIT);
    upd.inc_cls = cls_q;
  end

  cqac_quota u_quota (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_cls_i   (cls_q),
    .upd_i       (upd),
    .cnt_nx_o    (cnt_nx),
    .adm_o       (adm)
  );

  // Queue pointers; tail wraps at the queue depth
  assign tail_sum = (PTR_W+2)'(head_q) + (PTR_W+2)'(fill_q);
  assign tail     = (tail_sum >= (PTR_W+2)'(QUEUE_DEPTH))
                    ? PTR_W'(tail_sum - (PTR_W+2)'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
  assign head_inc = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else if (commit) begin
      if (pop) head_q <= head_inc;
      if (verdict == V_TAKEN) begin
        fill_q <= fill_q - FILL_W'(1);
      end else if ((verdict == V_ADMIT) && !evict) begin
        fill_q <= fill_q + FILL_W'(1);
      end
    end
  end

  cqac_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo_ram (
    .clk_i     (clk_i),
    .wr_en_i   (commit && (verdict == V_ADMIT)),
    .wr_addr_i (tail),
    .wr_data_i ({cls_q, tag_q}),
    .rd_en_i   ((state_q == ST_EXEC) && need_read),
    .rd_addr_i (head_q),
    .rd_data_o (rd_data)
  );

  // Result register
  assign item_tag = pop ? TAG_W'(rd_tag) : '0;
  assign item_cls = pop ? rd_cls : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_user_q <= verdict;
      out_data_q <= {1'b0, cnt_nx.refr, cnt_nx.rev, cnt_nx.fwd, cnt_nx.total,
                     item_cls, item_tag, evict};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

`default_nettype wire

[rtl/core/cqac_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module cqac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        wr_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]                            wr_data_i,
  input  wire logic                                        rd_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output      logic [WIDTH-1:0]                            rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read, holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[rtl/core/cqac_quota.sv]
// Quota registers, in-flight counters and the class admission check.
// Depends on cqac_pkg.
`default_nettype none

module cqac_quota
  import cqac_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [QUOTA_W-1:0]   cfg_data_i,
  input  wire logic [CLS_W-1:0]     req_cls_i,
  input  wire cnt_upd_t             upd_i,
  output      cnt_t                 cnt_nx_o,
  output      admit_t               adm_o
);

  localparam int SW = $clog2(GLOBAL_CAP + 1) + 2;

  logic [QUOTA_W-1:0] fwd_quota_q, rev_quota_q, ref_quota_q;
  cnt_t               cnt_q, cnt_d;
  logic [QUOTA_W-1:0] unused_rev, unused_ref;
  logic [QUOTA_W:0]   rev_limit;
  logic signed [SW-1:0] eff, eff_min, fq_s, cf_s;
  logic               fit_fwd, fit_rev, fit_ref;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] clamp_dec(input logic [CNT_W-1:0] v);
    return (v == '0) ? v : v - CNT_W'(1);
  endfunction

  function automatic logic is_cls(input logic [CLS_W-1:0] c, input logic [CLS_W-1:0] k);
    logic r;
    case (k)
      CLS_FWD: r = (c == CLS_FWD);
      CLS_REF: r = (c == CLS_REF);
      default: r = (c == CLS_REV) || (c == CLS_ALT);
    endcase
    return r;
  endfunction

  // Quota registers; a zero write restores the default
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_quota_q <= FWD_QUOTA_RST;
      rev_quota_q <= REV_QUOTA_RST;
      ref_quota_q <= REF_QUOTA_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FWD_QUOTA: fwd_quota_q <= (cfg_data_i == '0) ? FWD_QUOTA_RST : cfg_data_i;
        REG_REV_QUOTA: rev_quota_q <= (cfg_data_i == '0) ? REV_QUOTA_RST : cfg_data_i;
        REG_REF_QUOTA: ref_quota_q <= (cfg_data_i == '0) ? REF_QUOTA_RST : cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next counts: eviction or completion first, then admission
  always_comb begin
    cnt_d = cnt_q;
    if (upd_i.dec_en) begin
      cnt_d.total = clamp_dec(cnt_d.total);
      if (is_cls(upd_i.dec_cls, CLS_FWD)) cnt_d.fwd  = clamp_dec(cnt_d.fwd);
      if (is_cls(upd_i.dec_cls, CLS_REV)) cnt_d.rev  = clamp_dec(cnt_d.rev);
      if (is_cls(upd_i.dec_cls, CLS_REF)) cnt_d.refr = clamp_dec(cnt_d.refr);
    end
    if (upd_i.inc_en) begin
      cnt_d.total = sat_inc(cnt_d.total);
      if (is_cls(upd_i.inc_cls, CLS_FWD)) cnt_d.fwd  = sat_inc(cnt_d.fwd);
      if (is_cls(upd_i.inc_cls, CLS_REV)) cnt_d.rev  = sat_inc(cnt_d.rev);
      if (is_cls(upd_i.inc_cls, CLS_REF)) cnt_d.refr = sat_inc(cnt_d.refr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (upd_i.commit) begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_nx_o = cnt_d;

  // Unused reservations
  assign unused_rev = (rev_quota_q > cnt_q.rev)  ? rev_quota_q - cnt_q.rev  : '0;
  assign unused_ref = (ref_quota_q > cnt_q.refr) ? ref_quota_q - cnt_q.refr : '0;

  // Refresh: own quota. Reverse: may borrow unused refresh quota.
  assign fit_ref   = cnt_q.refr < ref_quota_q;
  assign rev_limit = {1'b0, rev_quota_q} + {1'b0, unused_ref};
  assign fit_rev   = {1'b0, cnt_q.rev} < rev_limit;

  // Forward: min(quota, cap minus unused reservations)
  assign fq_s    = $signed(SW'(fwd_quota_q));
  assign cf_s    = $signed(SW'(cnt_q.fwd));
  assign eff     = $signed(SW'(GLOBAL_CAP)) - $signed(SW'(unused_rev))
                   - $signed(SW'(unused_ref));
  assign eff_min = (eff > fq_s) ? fq_s : eff;
  assign fit_fwd = cf_s < eff_min;

  always_comb begin
    adm_o.cap_hit = SW'(cnt_q.total) >= SW'(GLOBAL_CAP);
    case (req_cls_i)
      CLS_FWD: adm_o.fits = fit_fwd;
      CLS_REF: adm_o.fits = fit_ref;
      default: adm_o.fits = fit_rev;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/cqac_checker.sv]
// Port-level checker for class_quota_admission_control, bound to the top level.
// Depends on cqac_pkg.
`default_nettype none

module cqac_checker
  import cqac_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid_i,
  input wire logic                  s_axis_tready_o,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input wire logic [OUT_USER_W-1:0] m_axis_tuser_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // One request in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while another is in work");

  // Verdict codes stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o <= OUT_USER_W'(V_DONE)))
    else $error("verdict out of range");

  // Eviction only goes with an admission
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> (m_axis_tuser_o == OUT_USER_W'(V_ADMIT)))
    else $error("drop without admission");

  // Results without a take or eviction carry no item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != OUT_USER_W'(V_ADMIT))
      && (m_axis_tuser_o != OUT_USER_W'(V_TAKEN)) |-> (m_axis_tdata_o[18:0] == '0))
    else $error("item fields set without take or eviction");

endmodule

bind class_quota_admission_control cqac_checker u_cqac_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
